### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the run-length decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk, skipped while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every rising edge of aclk, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### hw/rtl/rlvd_pkg.sv
// Package of types, constants and helpers for the run-length varint decoder.
`timescale 1ns / 1ps

package rlvd_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int SHIFT_W     = 6;
    localparam int CHUNK_W     = 7;
    localparam int SHIFT_MAX   = (1 << SHIFT_W) - 1;
    localparam int WIDE_W      = SHIFT_MAX + CHUNK_W;
    localparam int RUN_COUNT_W = 32;

    localparam logic [7:0] CONT_MASK = 8'h80;
    localparam logic [7:0] DATA_MASK = 8'h7F;
    localparam logic [SHIFT_W:0] CHUNK_STEP = (SHIFT_W + 1)'(CHUNK_W);

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SHIFT_W-1:0]    shift_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        logic [7:0]             run_value;
        logic [RUN_COUNT_W-1:0] run_count;
        logic                   count_overflow;
        logic                   truncated;
    } result_t;

    function automatic logic [RUN_COUNT_W-1:0] to_run_count(input count_t acc);
        logic [WIDE_W-1:0] ext;
        ext = WIDE_W'(acc);
        return ext[RUN_COUNT_W-1:0];
    endfunction

endpackage

### hw/rtl/rlvd_in_stage.sv
// Input register stage of the run-length varint decoder.
`timescale 1ns / 1ps

module rlvd_in_stage
    import rlvd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

### hw/rtl/rlvd_decode.sv
// Run state, count accumulation and result register of the run-length varint decoder.
`timescale 1ns / 1ps

module rlvd_decode
    import rlvd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic       phase_reg;
    logic       phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    count_t     acc_reg;
    count_t     acc_next;
    shift_t     shift_reg;
    shift_t     shift_next;
    logic       ovf_reg;
    logic       ovf_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;
    result_t    out_next;

    logic              fire;
    logic [7:0]        byte_masked;
    logic [CHUNK_W-1:0] chunk;
    logic [WIDE_W-1:0] wide;
    logic              ovf_calc;
    count_t            acc_calc;
    logic [SHIFT_W:0]  shift_sum;
    shift_t            shift_calc;
    logic              is_last;

    assign in_ready = !out_valid_reg || m_ready;
    assign fire     = in_valid && in_ready;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        byte_masked = in_item.data_byte & DATA_MASK;
        chunk       = byte_masked[CHUNK_W-1:0];
        wide        = WIDE_W'(chunk) << shift_reg;
        ovf_calc    = ovf_reg || (|wide[WIDE_W-1:COUNT_BITS]);
        acc_calc    = ovf_calc ? '1 : (acc_reg | wide[COUNT_BITS-1:0]);
        shift_sum   = {1'b0, shift_reg} + CHUNK_STEP;
        shift_calc  = (shift_sum > (SHIFT_W + 1)'(SHIFT_MAX)) ? '1 : shift_sum[SHIFT_W-1:0];
        is_last     = (in_item.data_byte & CONT_MASK) == 8'h00;
    end

    always_comb begin
        phase_next     = phase_reg;
        held_next      = held_reg;
        acc_next       = acc_reg;
        shift_next     = shift_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        if (fire) begin
            if (!phase_reg) begin
                held_next  = in_item.data_byte;
                acc_next   = '0;
                shift_next = '0;
                ovf_next   = 1'b0;
                if (in_item.end_of_stream) begin
                    out_valid_next          = 1'b1;
                    out_next.run_value      = in_item.data_byte;
                    out_next.run_count      = '0;
                    out_next.count_overflow = 1'b0;
                    out_next.truncated      = 1'b1;
                    phase_next              = 1'b0;
                end else begin
                    phase_next = 1'b1;
                end
            end else if (is_last || in_item.end_of_stream) begin
                out_valid_next          = 1'b1;
                out_next.run_value      = held_reg;
                out_next.run_count      = to_run_count(acc_calc);
                out_next.count_overflow = ovf_calc;
                out_next.truncated      = !is_last;
                phase_next              = 1'b0;
                acc_next                = '0;
                shift_next              = '0;
                ovf_next                = 1'b0;
            end else begin
                acc_next   = acc_calc;
                shift_next = shift_calc;
                ovf_next   = ovf_calc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg  <= held_next;
        acc_reg   <= acc_next;
        shift_reg <= shift_next;
        ovf_reg   <= ovf_next;
        out_reg   <= out_next;
    end

endmodule

### hw/rtl/run_length_varint_decoder_top.sv
// Run-length decoder with base-128 counts: one stream byte enters per item on the s_ side,
// a value byte followed by little-endian 7-bit count bytes (bit 7 set means more follow).
// Each run leaves on the m_ side as value, 32-bit saturated count, overflow and truncated
// flags; a stream that ends mid-run gives its partial run flagged as truncated. The block
// takes one byte every cycle unless m_ready stalls it: an input register and a result
// register bracket the combinational shift, OR and phase logic, so a last byte passes both
// before its result appears, and back-pressure on m_ready reaches s_ready through those two stages.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module run_length_varint_decoder_top
    import rlvd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_end_of_stream,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [7:0]      m_run_value,
    output logic [RUN_COUNT_W-1:0] m_run_count,
    output logic                   m_count_overflow,
    output logic                   m_truncated
);

    item_t   s_item;
    item_t   core_item;
    logic    core_valid;
    logic    core_ready;
    result_t result;

    assign s_item.data_byte     = s_data_byte;
    assign s_item.end_of_stream = s_end_of_stream;

    rlvd_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    rlvd_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (core_valid),
        .in_ready (core_ready),
        .in_item  (core_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_run_value      = $signed(result.run_value);
    assign m_run_count      = result.run_count;
    assign m_count_overflow = result.count_overflow;
    assign m_truncated      = result.truncated;

    `ASSERT_CLK(a_eos_gives_result, core_valid && core_ready && core_item.end_of_stream |=> m_valid, "end of stream item left no result")
    `ASSERT_CLK(a_overflow_saturates, m_valid && m_count_overflow |-> m_run_count == to_run_count('1), "overflowed count not saturated")
    `ASSERT_CLK_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid && !core_valid, "valid set after reset")

endmodule

### dv/run_length_varint_decoder_top_tb.sv
// Self-checking testbench for the run-length varint decoder: byte streams in, runs checked.
`timescale 1ns / 1ps

module run_length_varint_decoder_top_tb;
    import rlvd_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 480;

    class run_scoreboard;
        result_t pending[$];
        int      errors;
        logic    counting;
        logic [7:0] value_hold;
        count_t  count_acc;
        shift_t  bit_pos;
        logic    saturated;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            counting   = 1'b0;
            value_hold = '0;
            count_acc  = '0;
            bit_pos    = '0;
            saturated  = 1'b0;
        endfunction

        function void finish_run(input logic trunc);
            result_t r;
            r.run_value      = value_hold;
            r.run_count      = RUN_COUNT_W'(count_acc);
            r.count_overflow = saturated;
            r.truncated      = trunc;
            pending = {pending, r};
            clear_state();
        endfunction

        function void note_byte(input logic [7:0] b, input logic eos);
            logic [6:0]  chunk;
            logic [63:0] placed;
            int          p;
            if (!counting) begin
                clear_state();
                value_hold = b;
                if (eos) begin
                    finish_run(1'b1);
                end else begin
                    counting = 1'b1;
                end
            end else begin
                chunk = 7'(b & DATA_MASK);
                if (chunk != '0) begin
                    if (bit_pos >= COUNT_BITS) begin
                        saturated = 1'b1;
                    end else begin
                        placed = 64'(chunk) << bit_pos;
                        if ((placed >> COUNT_BITS) != '0) begin
                            saturated = 1'b1;
                        end
                        count_acc |= placed[COUNT_BITS-1:0];
                    end
                end
                if (saturated) begin
                    count_acc = '1;
                end
                p = int'(bit_pos) + CHUNK_W;
                bit_pos = (p > SHIFT_MAX) ? shift_t'(SHIFT_MAX) : shift_t'(p);
                if ((b & CONT_MASK) == '0) begin
                    finish_run(1'b0);
                end else if (eos) begin
                    finish_run(1'b1);
                end
            end
        endfunction

        function void check_run(input result_t got);
            result_t e;
            if (pending.size() == 0) begin
                $error("unexpected run: value %0d count %0d", $signed(got.run_value),
                       got.run_count);
                errors++;
            end else begin
                e = pending.pop_front();
                if (got.run_value !== e.run_value) begin
                    $error("run_value: expected %0d, got %0d", $signed(e.run_value),
                           $signed(got.run_value));
                    errors++;
                end
                if (got.run_count !== e.run_count) begin
                    $error("run_count: expected %0d, got %0d", e.run_count, got.run_count);
                    errors++;
                end
                if (got.count_overflow !== e.count_overflow) begin
                    $error("count_overflow: expected %0b, got %0b", e.count_overflow,
                           got.count_overflow);
                    errors++;
                end
                if (got.truncated !== e.truncated) begin
                    $error("truncated: expected %0b, got %0b", e.truncated, got.truncated);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_end_of_stream = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [7:0] m_run_value;
    logic [RUN_COUNT_W-1:0] m_run_count;
    logic        m_count_overflow;
    logic        m_truncated;

    run_scoreboard sb;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          n_sent = 0;
    int          idle_cycles = 0;
    int          hold_left = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;

    run_length_varint_decoder_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_stream  (s_end_of_stream),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_run_value      (m_run_value),
        .m_run_count      (m_run_count),
        .m_count_overflow (m_count_overflow),
        .m_truncated      (m_truncated)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.run_value      = m_run_value;
            got.run_count      = m_run_count;
            got.count_overflow = m_count_overflow;
            got.truncated      = m_truncated;
            sb.check_run(got);
        end
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_stream <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b, eos);
        n_sent++;
    endtask

    function automatic logic [6:0] pick_chunk();
        int r;
        r = $urandom_range(99);
        if (r < 15) return '0;
        if (r < 30) return '1;
        return 7'($urandom);
    endfunction

    task automatic send_run();
        int n_cont;
        int cut;
        int pick;
        pick = $urandom_range(99);
        if (pick < 6) begin
            n_cont = $urandom_range(1, 5);
            for (int i = 0; i < n_cont; i++) begin
                send_byte(8'($urandom), (i == n_cont - 1) || ($urandom_range(7) == 0));
            end
        end else begin
            n_cont = ($urandom_range(9) == 0) ? $urandom_range(4, 11) : $urandom_range(0, 3);
            cut = ($urandom_range(9) == 0) ? $urandom_range(0, n_cont) : -1;
            send_byte(8'($urandom), cut == 0);
            if (cut != 0) begin
                for (int i = 0; i < n_cont; i++) begin
                    send_byte({1'b1, pick_chunk()}, cut == i + 1);
                    if (cut == i + 1) break;
                end
                if (cut < 0) begin
                    send_byte({1'b0, pick_chunk()}, $urandom_range(19) == 0);
                end
            end
        end
    endtask

    initial begin
        int phase_end;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h01, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h55, 1'b0);
        repeat (4) send_byte(8'h80, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'hAA, 1'b0);
        repeat (6) send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                    hold_req     <= 1'b1;
                end
                1: begin
                    src_idle_pct  = 64;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 64;
                end
                default: begin
                    src_idle_pct  = 37;
                    snk_stall_pct = 37;
                end
            endcase
            phase_end = n_sent + PHASE_ITEMS;
            while (n_sent < phase_end) send_run();
        end

        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
